>>> rtl/fixed_size_pool_allocator_assert.svh
// assertion macros used by the checker file
`ifndef FIXED_SIZE_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_SIZE_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fspa check failed");

// next-cycle implication, checked outside reset
`define FSPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fspa check failed");

`endif

>>> rtl/fspa_pkg.sv
package fspa_pkg;

   // field widths of the words on the ports
   localparam int OP_W     = 2;
   localparam int SLOT_W   = 9;
   localparam int OFFSET_W = 19;
   localparam int FREE_W   = 10;
   localparam int BLOCKS_W = 5;
   localparam int SIZE_W   = 11;
   localparam int ROUND_W  = SIZE_W + 1;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [FREE_W-1:0]   free_type;
   typedef logic [BLOCKS_W-1:0] blocks_type;
   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [ROUND_W-1:0]  round_type;

   // operation codes
   localparam op_type OP_ALLOC = 2'd0;
   localparam op_type OP_FREE  = 2'd1;
   localparam op_type OP_GROW  = 2'd2;

   // status codes
   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_OOM = 1'b1;

   // free count saturates here
   localparam free_type FREE_MAX = 10'd1023;

   // item size after reset
   localparam size_type SIZE_RESET = 11'd8;

   // link memory command
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GROW,
      ST_RD,
      ST_POP,
      ST_WAIT
   } state_type;

endpackage

>>> rtl/fspa_link_mem.sv
module fspa_link_mem #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int LW    = 10
) (
   input  logic                  clock,
   input  fspa_pkg::mem_cmd_type cmd,
   input  logic [AW-1:0]         waddr,
   input  logic [LW-1:0]         wdata,
   input  logic [AW-1:0]         raddr,
   output logic [LW-1:0]         rd_data_ff
);

   logic [LW-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[raddr];
      end
   end

endmodule

>>> rtl/fspa_offset.sv
module fspa_offset #(
   parameter int LW = 10
) (
   input  logic                   clock,
   input  logic [LW-1:0]          slot,
   input  fspa_pkg::size_type     item_size,
   output fspa_pkg::offset_type   offset_ff
);

   fspa_pkg::round_type          size_sum;
   fspa_pkg::round_type          rounded;
   logic [LW+fspa_pkg::ROUND_W-1:0] product;

   // round item size up to a multiple of eight
   assign size_sum = {1'b0, item_size} + fspa_pkg::round_type'(7);
   assign rounded  = {size_sum[fspa_pkg::ROUND_W-1:3], 3'b000};
   assign product  = slot * rounded;

   // byte offset wraps to the port width
   always_ff @(posedge clock) begin
      offset_ff <= fspa_pkg::offset_type'(product);
   end

endmodule

>>> rtl/fspa_ctrl.sv
module fspa_ctrl #(
   parameter int SLOTS_PER_BLOCK = 32,
   parameter int MAX_BLOCKS      = 16,
   parameter int POOL_SLOTS      = 512,
   parameter int AW              = 9,
   parameter int LW              = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fspa_pkg::op_type        req_op,
   input  fspa_pkg::slot_type      req_slot,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_status,
   output fspa_pkg::slot_type      rsp_slot_out,
   output fspa_pkg::offset_type    rsp_byte_offset,
   output fspa_pkg::free_type      rsp_free_slots,
   output fspa_pkg::blocks_type    rsp_blocks_used,
   output fspa_pkg::mem_cmd_type   mem_cmd,
   output logic [AW-1:0]           mem_waddr,
   output logic [LW-1:0]           mem_wdata,
   output logic [AW-1:0]           mem_raddr,
   input  logic [LW-1:0]           mem_rd_data,
   output logic [LW-1:0]           mul_slot,
   input  fspa_pkg::offset_type    mul_offset
);

   localparam int BW = $clog2(MAX_BLOCKS + 1);
   localparam int SW = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
   localparam logic [LW-1:0] LIST_EMPTY = LW'(POOL_SLOTS);
   localparam logic [BW-1:0] BLOCK_LIM  = BW'(MAX_BLOCKS);
   localparam logic [SW-1:0] STEP_LAST  = SW'(SLOTS_PER_BLOCK - 1);
   localparam logic [31:0]   POOL_LIM   = 32'(POOL_SLOTS);

   fspa_pkg::state_type state_ff, state_in;
   logic [LW-1:0]       head_ff, head_in;
   fspa_pkg::free_type  free_ff, free_in;
   logic [BW-1:0]       block_ff, block_in;
   logic [LW-1:0]       fill_ff, fill_in;
   logic [SW-1:0]       step_ff, step_in;
   logic                alloc_ff, alloc_in;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic                   out_status_ff, out_status_in;
   fspa_pkg::slot_type     out_slot_ff, out_slot_in;
   fspa_pkg::offset_type   out_off_ff, out_off_in;
   fspa_pkg::free_type     out_free_ff, out_free_in;
   fspa_pkg::blocks_type   out_blocks_ff, out_blocks_in;

   // held result while the output register is busy
   logic                   res_status_ff, res_status_in;
   fspa_pkg::slot_type     res_slot_ff, res_slot_in;
   fspa_pkg::offset_type   res_off_ff, res_off_in;
   fspa_pkg::free_type     res_free_ff, res_free_in;
   fspa_pkg::blocks_type   res_blocks_ff, res_blocks_in;

   logic                 accept;
   logic                 out_open;
   logic                 head_empty;
   logic                 blocks_left;
   logic                 slot_ok;
   logic                 grow_last;
   fspa_pkg::free_type   free_inc;
   fspa_pkg::free_type   free_dec;
   logic                 fin;
   logic                 fin_status;
   fspa_pkg::slot_type   fin_slot;
   fspa_pkg::offset_type fin_off;

   assign req_stall   = (state_ff != fspa_pkg::ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_open    = !out_valid_ff || !rsp_stall;
   assign head_empty  = (head_ff == LIST_EMPTY);
   assign blocks_left = (block_ff < BLOCK_LIM);
   assign slot_ok     = (32'(req_slot) < POOL_LIM);
   assign grow_last   = (step_ff == STEP_LAST);
   assign free_inc    = (free_ff == fspa_pkg::FREE_MAX) ? free_ff : free_ff + 1'b1;
   assign free_dec    = (free_ff == '0) ? free_ff : free_ff - 1'b1;
   assign mul_slot    = head_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fspa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == fspa_pkg::OP_ALLOC && !head_empty) begin
                  state_in = fspa_pkg::ST_POP;
               end else if ((req_op == fspa_pkg::OP_ALLOC || req_op == fspa_pkg::OP_GROW)
                            && (req_op == fspa_pkg::OP_GROW || head_empty) && blocks_left) begin
                  state_in = fspa_pkg::ST_GROW;
               end else begin
                  state_in = out_open ? fspa_pkg::ST_IDLE : fspa_pkg::ST_WAIT;
               end
            end
         end
         fspa_pkg::ST_GROW: begin
            if (grow_last) begin
               if (alloc_ff) begin
                  state_in = fspa_pkg::ST_RD;
               end else begin
                  state_in = out_open ? fspa_pkg::ST_IDLE : fspa_pkg::ST_WAIT;
               end
            end
         end
         fspa_pkg::ST_RD: begin
            state_in = fspa_pkg::ST_POP;
         end
         fspa_pkg::ST_POP: begin
            state_in = out_open ? fspa_pkg::ST_IDLE : fspa_pkg::ST_WAIT;
         end
         fspa_pkg::ST_WAIT: begin
            if (out_open) begin
               state_in = fspa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fspa_pkg::ST_IDLE;
         end
      endcase
   end

   // list update and memory commands
   always_comb begin
      head_in    = head_ff;
      free_in    = free_ff;
      block_in   = block_ff;
      fill_in    = fill_ff;
      step_in    = step_ff;
      alloc_in   = alloc_ff;
      fin        = 1'b0;
      fin_status = fspa_pkg::STAT_OK;
      fin_slot   = '0;
      fin_off    = '0;
      mem_cmd    = '0;
      mem_waddr  = fill_ff[AW-1:0];
      mem_wdata  = head_ff;
      mem_raddr  = head_ff[AW-1:0];
      case (state_ff)
         fspa_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  fspa_pkg::OP_ALLOC: begin
                     if (!head_empty) begin
                        mem_cmd.rd_en = 1'b1;
                     end else if (blocks_left) begin
                        alloc_in = 1'b1;
                        step_in  = '0;
                     end else begin
                        fin        = 1'b1;
                        fin_status = fspa_pkg::STAT_OOM;
                     end
                  end
                  fspa_pkg::OP_FREE: begin
                     fin = 1'b1;
                     if (slot_ok) begin
                        mem_cmd.wr_en = 1'b1;
                        mem_waddr     = AW'(req_slot);
                        head_in       = LW'(req_slot);
                        free_in       = free_inc;
                     end
                  end
                  fspa_pkg::OP_GROW: begin
                     if (blocks_left) begin
                        alloc_in = 1'b0;
                        step_in  = '0;
                     end else begin
                        fin        = 1'b1;
                        fin_status = fspa_pkg::STAT_OOM;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         fspa_pkg::ST_GROW: begin
            // push the next slot of the new block
            mem_cmd.wr_en = 1'b1;
            head_in       = fill_ff;
            fill_in       = fill_ff + 1'b1;
            free_in       = free_inc;
            step_in       = step_ff + 1'b1;
            if (grow_last) begin
               block_in = block_ff + 1'b1;
               fin      = !alloc_ff;
            end
         end
         fspa_pkg::ST_RD: begin
            mem_cmd.rd_en = 1'b1;
         end
         fspa_pkg::ST_POP: begin
            // pop the head, link word arrives now
            fin      = 1'b1;
            fin_slot = fspa_pkg::slot_type'(head_ff);
            fin_off  = mul_offset;
            head_in  = mem_rd_data;
            free_in  = free_dec;
         end
         default: begin
         end
      endcase
   end

   // output register and held result
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_off_in    = out_off_ff;
      out_free_in   = out_free_ff;
      out_blocks_in = out_blocks_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_off_in    = res_off_ff;
      res_free_in   = res_free_ff;
      res_blocks_in = res_blocks_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == fspa_pkg::ST_WAIT) begin
         if (out_open) begin
            out_valid_in  = 1'b1;
            out_status_in = res_status_ff;
            out_slot_in   = res_slot_ff;
            out_off_in    = res_off_ff;
            out_free_in   = res_free_ff;
            out_blocks_in = res_blocks_ff;
         end
      end else if (fin) begin
         if (out_open) begin
            out_valid_in  = 1'b1;
            out_status_in = fin_status;
            out_slot_in   = fin_slot;
            out_off_in    = fin_off;
            out_free_in   = free_in;
            out_blocks_in = fspa_pkg::blocks_type'(block_in);
         end else begin
            res_status_in = fin_status;
            res_slot_in   = fin_slot;
            res_off_in    = fin_off;
            res_free_in   = free_in;
            res_blocks_in = fspa_pkg::blocks_type'(block_in);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fspa_pkg::ST_IDLE;
         head_ff      <= LIST_EMPTY;
         free_ff      <= '0;
         block_ff     <= '0;
         fill_ff      <= '0;
         step_ff      <= '0;
         alloc_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         block_ff     <= block_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         alloc_ff     <= alloc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_off_ff    <= out_off_in;
      out_free_ff   <= out_free_in;
      out_blocks_ff <= out_blocks_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_off_ff    <= res_off_in;
      res_free_ff   <= res_free_in;
      res_blocks_ff <= res_blocks_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_slot_out    = out_slot_ff;
   assign rsp_byte_offset = out_off_ff;
   assign rsp_free_slots  = out_free_ff;
   assign rsp_blocks_used = out_blocks_ff;

endmodule

>>> rtl/fixed_size_pool_allocator.sv
// Fixed-size slot pool with a last-in-first-out free list held in a link memory.
// Request channel (req_valid / req_stall): req_op selects allocate, free or grow;
// req_slot names the slot to free. One response word follows each request on
// rsp_valid / rsp_stall with status, slot, byte offset, free count and blocks used.
// Item size is written on csr_valid / csr_ready; the user must write it only while
// the block is idle (the block itself does not enforce this); csr_ready is always high.
// Steps from request accept to response valid (the response word is registered):
//   free, failed ops, unused code: done on accept, idle again unless a response waits
//   allocate from a non-empty list: link memory read, then pop
//   grow: one link written per cycle for each slot of the new block
//   allocate on an empty list: grow, read, pop
// One request is in work at a time.
// A response waiting under rsp_stall sits in the output register; the block
// finishes the next request meanwhile and holds its result until the output frees.
// Reset empties the list, zeroes the counts and sets item size to 8; the link
// memory needs no clearing since every link is written before it is read.
module fixed_size_pool_allocator #(
   parameter int SLOTS_PER_BLOCK = 32,
   parameter int MAX_BLOCKS      = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fspa_pkg::op_type      req_op,
   input  fspa_pkg::slot_type    req_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output fspa_pkg::slot_type    rsp_slot_out,
   output fspa_pkg::offset_type  rsp_byte_offset,
   output fspa_pkg::free_type    rsp_free_slots,
   output fspa_pkg::blocks_type  rsp_blocks_used,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  fspa_pkg::size_type    csr_item_size
);

   localparam int POOL_SLOTS = SLOTS_PER_BLOCK * MAX_BLOCKS;
   localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int LW = $clog2(POOL_SLOTS + 1);

   fspa_pkg::size_type    item_size_ff;
   fspa_pkg::mem_cmd_type mem_cmd;
   logic [AW-1:0]         mem_waddr;
   logic [LW-1:0]         mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [LW-1:0]         mem_rd_data;
   logic [LW-1:0]         mul_slot;
   fspa_pkg::offset_type  mul_offset;

   // item size register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_size_ff <= fspa_pkg::SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         item_size_ff <= csr_item_size;
      end
   end

   fspa_ctrl #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS),
      .POOL_SLOTS      (POOL_SLOTS),
      .AW              (AW),
      .LW              (LW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_free_slots  (rsp_free_slots),
      .rsp_blocks_used (rsp_blocks_used),
      .mem_cmd         (mem_cmd),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rd_data     (mem_rd_data),
      .mul_slot        (mul_slot),
      .mul_offset      (mul_offset)
   );

   fspa_link_mem #(
      .DEPTH (POOL_SLOTS),
      .AW    (AW),
      .LW    (LW)
   ) u_link_mem (
      .clock      (clock),
      .cmd        (mem_cmd),
      .waddr      (mem_waddr),
      .wdata      (mem_wdata),
      .raddr      (mem_raddr),
      .rd_data_ff (mem_rd_data)
   );

   fspa_offset #(
      .LW (LW)
   ) u_offset (
      .clock     (clock),
      .slot      (mul_slot),
      .item_size (item_size_ff),
      .offset_ff (mul_offset)
   );

endmodule

>>> rtl/fspa_checker.sv
`include "fixed_size_pool_allocator_assert.svh"

module fspa_checker #(
   parameter int MAX_BLOCKS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_status,
   input fspa_pkg::slot_type    rsp_slot_out,
   input fspa_pkg::offset_type  rsp_byte_offset,
   input fspa_pkg::blocks_type  rsp_blocks_used
);

   localparam fspa_pkg::blocks_type BLOCKS_FULL = fspa_pkg::blocks_type'(MAX_BLOCKS);

   // a stalled response word holds
   `FSPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_slot_out) && $stable(rsp_byte_offset))

   // out of memory only once every block is in use
   `FSPA_ASSERT_NOW(a_oom_full, clock, reset, rsp_valid && rsp_status == fspa_pkg::STAT_OOM, rsp_blocks_used == BLOCKS_FULL)

   // a failed request hands out nothing
   `FSPA_ASSERT_NOW(a_oom_zero, clock, reset, rsp_valid && rsp_status == fspa_pkg::STAT_OOM, rsp_slot_out == '0 && rsp_byte_offset == '0)

   // slot zero always sits at offset zero
   `FSPA_ASSERT_NOW(a_slot0_off, clock, reset, rsp_valid && rsp_slot_out == '0, rsp_byte_offset == '0)

endmodule

bind fixed_size_pool_allocator fspa_checker #(
   .MAX_BLOCKS (MAX_BLOCKS)
) u_fspa_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_slot_out    (rsp_slot_out),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_blocks_used (rsp_blocks_used)
);
